/* design/lpdw_pkg.sv */
`default_nettype none

package lpdw_pkg;

  // Field widths
  localparam int unsigned OP_W    = 2;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned CNT_W   = 14;
  localparam int unsigned TICK_W  = 16;
  localparam int unsigned HLEN_W  = 13;

  // Header length handling
  localparam logic [CNT_W-1:0]  LEN_HDR_ONLY   = CNT_W'(2);
  localparam logic [CNT_W-1:0]  LEN_ZERO_MEANS = CNT_W'(8194);
  localparam logic [TICK_W-1:0] TIMEOUT_RESET  = TICK_W'(100);

  // APB register map
  localparam int unsigned ADDR_W = 3;
  localparam int unsigned DATA_W = 32;
  localparam logic        REG_TIMEOUT = 1'b0;  // paddr[2] of the timeout register

  // Input operation codes
  typedef enum logic [OP_W-1:0] {
    OP_BYTE       = 2'd0,
    OP_TICK       = 2'd1,
    OP_CONNECT    = 2'd2,
    OP_DISCONNECT = 2'd3
  } op_t;

  // Framer phase
  typedef enum logic [1:0] {
    PH_HDR1 = 2'd0,
    PH_HDR2 = 2'd1,
    PH_DATA = 2'd2
  } phase_t;

  // Result event codes
  typedef enum logic {
    EV_BYTE    = 1'b0,
    EV_TIMEOUT = 1'b1
  } event_t;

  // One result word
  typedef struct packed {
    logic              event_res;
    logic [BYTE_W-1:0] out_byte;
    logic [CNT_W-1:0]  byte_index;
    logic [CNT_W-1:0]  msg_length;
    logic              last_of_message;
  } res_t;

endpackage

`default_nettype wire

/* design/lpdw_cfg.sv */
`default_nettype none

module lpdw_cfg
  import lpdw_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic      [DATA_W-1:0] prdata,
  output logic                   pready,
  output logic      [TICK_W-1:0] timeout_ticks
);

  logic [TICK_W-1:0] timeout_r;
  logic              wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && (paddr[2] == REG_TIMEOUT);

  // Timeout reload register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= TIMEOUT_RESET;
    end else if (wr_en) begin
      timeout_r <= pwdata[TICK_W-1:0];
    end
  end

  // Read back
  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_TIMEOUT) begin
      prdata = {{(DATA_W-TICK_W){1'b0}}, timeout_r};
    end
  end

  assign timeout_ticks = timeout_r;

endmodule

`default_nettype wire

/* design/lpdw_core.sv */
`default_nettype none

module lpdw_core
  import lpdw_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              acc,
  input  wire logic [OP_W-1:0]   operation,
  input  wire logic [BYTE_W-1:0] data_byte,
  input  wire logic [TICK_W-1:0] timeout_ticks,
  output logic                   res_valid,
  output res_t                   res
);

  phase_t            phase_r, phase_nxt;
  logic [BYTE_W-1:0] low_hdr_r, low_hdr_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [CNT_W-1:0]  flen_r, flen_nxt;
  logic [TICK_W-1:0] wdog_r, wdog_nxt;
  logic              active_r, active_nxt;

  logic [CNT_W-1:0]  hdr_len;
  logic [CNT_W-1:0]  cnt_inc;
  logic              data_last;

  // Header length and data position
  assign hdr_len   = {1'b0, data_byte[HLEN_W-BYTE_W-1:0], low_hdr_r};
  assign cnt_inc   = count_r + CNT_W'(1);
  assign data_last = (cnt_inc >= flen_r);

  // Next state and result for one accepted word
  always_comb begin
    phase_nxt   = phase_r;
    low_hdr_nxt = low_hdr_r;
    count_nxt   = count_r;
    flen_nxt    = flen_r;
    wdog_nxt    = wdog_r;
    active_nxt  = active_r;
    res_valid   = 1'b0;
    res         = '0;
    if (acc) begin
      unique case (op_t'(operation))
        OP_BYTE: begin
          res_valid     = 1'b1;
          res.event_res = EV_BYTE;
          res.out_byte  = data_byte;
          unique case (phase_r)
            PH_HDR2: begin
              count_nxt      = LEN_HDR_ONLY;
              res.byte_index = CNT_W'(1);
              if (hdr_len == LEN_HDR_ONLY) begin
                flen_nxt            = LEN_HDR_ONLY;
                phase_nxt           = PH_HDR1;
                res.msg_length      = LEN_HDR_ONLY;
                res.last_of_message = 1'b1;
              end else begin
                flen_nxt       = (hdr_len == '0) ? LEN_ZERO_MEANS : hdr_len;
                phase_nxt      = PH_DATA;
                res.msg_length = (hdr_len == '0) ? LEN_ZERO_MEANS : hdr_len;
              end
            end
            PH_DATA: begin
              res.byte_index      = count_r;
              res.msg_length      = flen_r;
              res.last_of_message = data_last;
              if (data_last) begin
                phase_nxt = PH_HDR1;
                count_nxt = '0;
                wdog_nxt  = timeout_ticks;
              end else begin
                count_nxt = cnt_inc;
              end
            end
            default: begin
              // first header byte, also the unused phase code
              low_hdr_nxt = data_byte;
              phase_nxt   = PH_HDR2;
            end
          endcase
        end
        OP_TICK: begin
          if (active_r) begin
            if (wdog_r == '0) begin
              active_nxt    = 1'b0;
              res_valid     = 1'b1;
              res.event_res = EV_TIMEOUT;
            end else begin
              wdog_nxt = wdog_r - TICK_W'(1);
            end
          end
        end
        OP_CONNECT: begin
          phase_nxt  = PH_HDR1;
          count_nxt  = '0;
          flen_nxt   = '0;
          wdog_nxt   = timeout_ticks;
          active_nxt = 1'b1;
        end
        OP_DISCONNECT: begin
          active_nxt = 1'b0;
        end
        default: begin
          active_nxt = active_r;
        end
      endcase
    end
  end

  // Framer and watchdog state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_HDR1;
      low_hdr_r <= '0;
      count_r   <= '0;
      flen_r    <= '0;
      wdog_r    <= '0;
      active_r  <= 1'b0;
    end else begin
      phase_r   <= phase_nxt;
      low_hdr_r <= low_hdr_nxt;
      count_r   <= count_nxt;
      flen_r    <= flen_nxt;
      wdog_r    <= wdog_nxt;
      active_r  <= active_nxt;
    end
  end

endmodule

`default_nettype wire

/* design/lpdw_outbuf.sv */
`default_nettype none

module lpdw_outbuf
  import lpdw_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire res_t push_data,
  output logic      full,
  output logic      out_valid,
  input  wire logic out_stall,
  output res_t      out_data
);

  logic main_vld_r, main_vld_nxt;
  logic skid_vld_r, skid_vld_nxt;
  res_t main_r, main_nxt;
  res_t skid_r, skid_nxt;
  logic pop;

  assign pop       = main_vld_r && !out_stall;
  assign out_valid = main_vld_r;
  assign out_data  = main_r;
  // skid occupied: upstream must hold off
  assign full      = skid_vld_r;

  // Main and skid slot control
  always_comb begin
    main_vld_nxt = main_vld_r;
    skid_vld_nxt = skid_vld_r;
    main_nxt     = main_r;
    skid_nxt     = skid_r;
    if (pop) begin
      if (skid_vld_r) begin
        main_nxt     = skid_r;
        skid_vld_nxt = 1'b0;
      end else begin
        main_vld_nxt = push;
        main_nxt     = push_data;
      end
    end else if (!main_vld_r) begin
      main_vld_nxt = push;
      main_nxt     = push_data;
    end else if (push) begin
      skid_vld_nxt = 1'b1;
      skid_nxt     = push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_vld_r <= 1'b0;
      skid_vld_r <= 1'b0;
    end else begin
      main_vld_r <= main_vld_nxt;
      skid_vld_r <= skid_vld_nxt;
    end
  end

  // Payload slots
  always_ff @(posedge clk) begin
    main_r <= main_nxt;
    skid_r <= skid_nxt;
  end

endmodule

`default_nettype wire

/* design/length_prefixed_deframer_watchdog.sv */
`default_nettype none

// Channel   Direction  Handshake             Word
// in_       input      in_valid / in_stall   operation, data_byte
// out_      output     out_valid / out_stall event_res, out_byte, byte_index,
//                                            msg_length, last_of_message
// cfg       input      APB psel/penable      timeout_ticks at address 0
//
// One word is accepted per cycle while in_stall is low; its result, if any, is
// on out_ the next cycle unless older results are still waiting there.
// Sustained rate is one word per clock while out_stall stays low, set by the
// single framer/watchdog update. Output has a main register and a skid slot;
// in_stall is registered and rises only while the skid slot holds a word.
// rst_n is synchronous: framer idle, link inactive, watchdog zero, timeout 100.

module length_prefixed_deframer_watchdog
  import lpdw_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  // input channel
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [OP_W-1:0]   in_operation,
  input  wire logic [BYTE_W-1:0] in_data_byte,
  // result channel
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic                   out_event_res,
  output logic      [BYTE_W-1:0] out_out_byte,
  output logic      [CNT_W-1:0]  out_byte_index,
  output logic      [CNT_W-1:0]  out_msg_length,
  output logic                   out_last_of_message,
  // configuration
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic      [DATA_W-1:0] prdata,
  output logic                   pready
);

  logic [TICK_W-1:0] timeout_ticks;
  logic              acc;
  logic              res_valid;
  logic              full;
  res_t              res;
  res_t              out_data;

  assign in_stall = full;
  assign acc      = in_valid && !full;

  lpdw_cfg u_cfg (
    .clk           (clk),
    .rst_n         (rst_n),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .timeout_ticks (timeout_ticks)
  );

  lpdw_core u_core (
    .clk           (clk),
    .rst_n         (rst_n),
    .acc           (acc),
    .operation     (in_operation),
    .data_byte     (in_data_byte),
    .timeout_ticks (timeout_ticks),
    .res_valid     (res_valid),
    .res           (res)
  );

  lpdw_outbuf u_outbuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_valid),
    .push_data (res),
    .full      (full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // Result fields
  assign out_event_res       = out_data.event_res;
  assign out_out_byte        = out_data.out_byte;
  assign out_byte_index      = out_data.byte_index;
  assign out_msg_length      = out_data.msg_length;
  assign out_last_of_message = out_data.last_of_message;

endmodule

`default_nettype wire

/* bench/length_prefixed_deframer_watchdog_tb.sv */
module length_prefixed_deframer_watchdog_tb;
  import lpdw_pkg::*;

  localparam int unsigned SETTLE    = 8;
  localparam int unsigned HOLD_LEN  = 300;
  localparam int unsigned IDLE_PCT  = 6;
  localparam int unsigned RUN_LIMIT = 3_000_000;
  localparam logic [ADDR_W-1:0] TIMEOUT_ADDR  = {REG_TIMEOUT, 2'b00};
  localparam logic [ADDR_W-1:0] UNMAPPED_ADDR = {~REG_TIMEOUT, 2'b00};

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  logic [OP_W-1:0]   in_operation;
  logic [BYTE_W-1:0] in_data_byte;
  logic              out_valid;
  logic              out_stall;
  logic              out_event_res;
  logic [BYTE_W-1:0] out_out_byte;
  logic [CNT_W-1:0]  out_byte_index;
  logic [CNT_W-1:0]  out_msg_length;
  logic              out_last_of_message;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  // phase-by-phase watchdog reload values for the random traffic
  logic [TICK_W-1:0] reload_plan [6] = '{16'd3, 16'd0, 16'd1, 16'd20, 16'hFFFF, 16'd5};

  bit          steady;      // no idling on either side
  bit          hold_req;    // asks the receiver for one long hold-off
  int unsigned bytes_sent;
  res_t        taken_result;

  length_prefixed_deframer_watchdog dut (.*);

  // Deframer and watchdog predictor with its queue of outstanding results
  class deframe_scoreboard;
    logic [TICK_W-1:0] reload_ticks;
    phase_t            phase;
    logic [BYTE_W-1:0] hdr_low;
    logic [CNT_W-1:0]  pos;
    logic [CNT_W-1:0]  frame_len;
    logic [TICK_W-1:0] wdog;
    bit                link_up;
    res_t              due_results[$];
    int                errors;

    function new();
      reload_ticks = TIMEOUT_RESET;
      phase        = PH_HDR1;
      hdr_low      = '0;
      pos          = '0;
      frame_len    = '0;
      wdog         = '0;
      link_up      = 1'b0;
      errors       = 0;
    endfunction

    function void push_result(event_t ev, logic [BYTE_W-1:0] b, logic [CNT_W-1:0] idx,
                              logic [CNT_W-1:0] len, logic last);
      res_t r;
      r.event_res       = ev;
      r.out_byte        = b;
      r.byte_index      = idx;
      r.msg_length      = len;
      r.last_of_message = last;
      due_results.push_back(r);
    endfunction

    // one accepted input word
    function void accept_word(op_t op, logic [BYTE_W-1:0] b);
      logic [15:0]      hdr;
      logic [CNT_W-1:0] len;
      logic [CNT_W-1:0] nxt;
      logic             last;
      case (op)
        OP_BYTE: begin
          case (phase)
            PH_HDR2: begin
              hdr = {b, hdr_low};
              len = CNT_W'(hdr[HLEN_W-1:0]);
              pos = CNT_W'(2);
              if (len == LEN_HDR_ONLY) begin
                frame_len = LEN_HDR_ONLY;
                phase     = PH_HDR1;
                push_result(EV_BYTE, b, CNT_W'(1), LEN_HDR_ONLY, 1'b1);
              end else begin
                if (len == '0) len = LEN_ZERO_MEANS;
                frame_len = len;
                phase     = PH_DATA;
                push_result(EV_BYTE, b, CNT_W'(1), len, 1'b0);
              end
            end
            PH_DATA: begin
              nxt  = pos + 1'b1;
              last = (nxt >= frame_len);
              push_result(EV_BYTE, b, pos, frame_len, last);
              if (last) begin
                phase = PH_HDR1;
                pos   = '0;
                wdog  = reload_ticks;
              end else begin
                pos = nxt;
              end
            end
            default: begin
              // first header byte, also taken for the unused phase code
              hdr_low = b;
              phase   = PH_HDR2;
              push_result(EV_BYTE, b, '0, '0, 1'b0);
            end
          endcase
        end
        OP_TICK: begin
          if (link_up) begin
            if (wdog == '0) begin
              link_up = 1'b0;
              push_result(EV_TIMEOUT, '0, '0, '0, 1'b0);
            end else begin
              wdog = wdog - 1'b1;
            end
          end
        end
        OP_CONNECT: begin
          phase     = PH_HDR1;
          pos       = '0;
          frame_len = '0;
          wdog      = reload_ticks;
          link_up   = 1'b1;
        end
        OP_DISCONNECT: begin
          link_up = 1'b0;
        end
      endcase
    endfunction

    function void compare_field(string name, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        errors++;
      end
    endfunction

    // one accepted result word against the oldest prediction
    function void check_word(res_t got);
      res_t want;
      if (due_results.size() == 0) begin
        $error("result with none outstanding: event_res %0d out_byte %0d",
               got.event_res, got.out_byte);
        errors++;
        return;
      end
      want = due_results.pop_front();
      compare_field("event_res", want.event_res, got.event_res);
      compare_field("out_byte", want.out_byte, got.out_byte);
      compare_field("byte_index", want.byte_index, got.byte_index);
      compare_field("msg_length", want.msg_length, got.msg_length);
      compare_field("last_of_message", want.last_of_message, got.last_of_message);
    endfunction
  endclass

  deframe_scoreboard sb = new();

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // handshake monitor: both channels sampled at the rising edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) sb.accept_word(op_t'(in_operation), in_data_byte);
      if (out_valid && !out_stall) begin
        taken_result.event_res       = out_event_res;
        taken_result.out_byte        = out_out_byte;
        taken_result.byte_index      = out_byte_index;
        taken_result.msg_length      = out_msg_length;
        taken_result.last_of_message = out_last_of_message;
        sb.check_word(taken_result);
      end
    end
  end

  // result side: random stalls, one long hold-off on request
  initial begin
    int unsigned hold_left;
    hold_left = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left != 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_LEN - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= !steady && ($urandom_range(0, 99) < IDLE_PCT);
      end
    end
  end

  // offer one word, with random gaps before it; returns at a falling edge
  task automatic send_word(op_t op, logic [BYTE_W-1:0] b);
    while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_operation <= op;
    in_data_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    if (op == OP_BYTE) bytes_sent++;
  endtask

  // stop offering and let every outstanding result arrive
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(negedge clk);
    while (sb.due_results.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  // APB setup and access cycles; reads are checked against the model
  task automatic apb_access(bit wr, logic [ADDR_W-1:0] addr, logic [DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (wr && addr == TIMEOUT_ADDR) begin
      sb.reload_ticks = data[TICK_W-1:0];
    end else if (!wr && addr == TIMEOUT_ADDR && prdata !== DATA_W'(sb.reload_ticks)) begin
      $error("timeout_ticks: expected %0d, got %0d", sb.reload_ticks, prdata);
      sb.errors++;
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_timeout(logic [TICK_W-1:0] ticks);
    apb_access(1'b1, TIMEOUT_ADDR, DATA_W'(ticks));
    apb_access(1'b0, TIMEOUT_ADDR, '0);
  endtask

  // header plus body; a length field of zero stands for the longest message
  task automatic send_message(int unsigned len, bit cut);
    logic [CNT_W-1:0] l;
    int unsigned      full;
    int unsigned      body;
    l    = CNT_W'(len);
    full = (len == 0) ? LEN_ZERO_MEANS : len;
    body = (full == 1) ? 1 : (full > 2 ? full - 2 : 0);
    if (cut) body = $urandom_range(0, body);
    send_word(OP_BYTE, l[7:0]);
    send_word(OP_BYTE, {3'($urandom_range(0, 7)), l[12:8]});
    repeat (body) begin
      if ($urandom_range(0, 99) < 10) send_word(OP_TICK, BYTE_W'($urandom));
      send_word(OP_BYTE, BYTE_W'($urandom));
    end
  endtask

  // mostly whole messages with ticks between, plus stray words and restarts
  task automatic run_traffic(int unsigned n);
    int unsigned start;
    int unsigned r;
    int unsigned len;
    bit          cut;
    start = bytes_sent;
    send_word(OP_CONNECT, '0);
    while (bytes_sent - start < n) begin
      r = $urandom_range(0, 99);
      if (r < 8) begin
        send_word(op_t'($urandom_range(0, 3)), BYTE_W'($urandom));
      end else if (r < 15) begin
        send_word(OP_CONNECT, BYTE_W'($urandom));
      end else if (r < 17) begin
        send_word(OP_DISCONNECT, BYTE_W'($urandom));
      end else begin
        r = $urandom_range(0, 99);
        if (r < 8) len = 2;
        else if (r < 9) len = $urandom_range(256, 600);
        else if (r < 29) len = $urandom_range(13, 80);
        else len = $urandom_range(1, 12);
        cut = ($urandom_range(0, 99) < 5);
        send_message(len, cut);
        if (cut) send_word(OP_CONNECT, '0);
        repeat ($urandom_range(0, 2)) send_word(OP_TICK, '0);
      end
    end
  endtask

  initial begin
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_operation = OP_BYTE;
    in_data_byte = '0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    steady       = 1'b0;
    hold_req     = 1'b0;
    bytes_sent   = 0;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // link down: tick ignored, a length-one message still passes
    send_word(OP_TICK, 8'hFF);
    send_word(OP_BYTE, 8'h01);
    send_word(OP_BYTE, 8'h00);
    send_word(OP_BYTE, 8'hAB);
    send_word(OP_CONNECT, 8'h00);
    // header-only message, upper header bits ignored
    send_word(OP_BYTE, 8'h02);
    send_word(OP_BYTE, 8'hE0);
    send_word(OP_BYTE, 8'h05);
    send_word(OP_BYTE, 8'h00);
    send_word(OP_BYTE, 8'hFF);
    send_word(OP_BYTE, 8'h00);
    send_word(OP_BYTE, 8'h5A);
    send_word(OP_TICK, 8'h00);
    // zero length field, disconnect keeps the framer position
    send_word(OP_BYTE, 8'h00);
    send_word(OP_BYTE, 8'h00);
    send_word(OP_BYTE, 8'h11);
    send_word(OP_DISCONNECT, 8'h00);
    send_word(OP_BYTE, 8'h22);
    send_word(OP_CONNECT, 8'h00);
    // largest length field, cut short by a reconnect
    send_word(OP_BYTE, 8'hFF);
    send_word(OP_BYTE, 8'hFF);
    send_word(OP_BYTE, 8'h80);
    send_word(OP_CONNECT, 8'h00);
    wait_drained();

    // zero reload: every active tick times out
    set_timeout(16'h0000);
    send_word(OP_CONNECT, 8'h00);
    send_word(OP_TICK, 8'h00);
    send_word(OP_TICK, 8'h00);
    send_word(OP_CONNECT, 8'h00);
    send_word(OP_BYTE, 8'h03);
    send_word(OP_BYTE, 8'h00);
    send_word(OP_BYTE, 8'h7E);
    send_word(OP_TICK, 8'h00);
    wait_drained();

    // unmapped address leaves the timeout alone
    apb_access(1'b1, UNMAPPED_ADDR, 32'hFFFF_0055);
    apb_access(1'b0, TIMEOUT_ADDR, '0);

    // one long message; the receiver holds off part way through
    set_timeout(16'hFFFF);
    send_word(OP_CONNECT, 8'h00);
    fork
      send_message(300, 1'b0);
      begin
        repeat (100) @(posedge clk);
        hold_req = 1'b1;
      end
    join
    wait_drained();

    // random traffic under several reload values
    foreach (reload_plan[i]) begin
      set_timeout(reload_plan[i]);
      steady = (i == 3);
      run_traffic(180);
      wait_drained();
    end

    if (sb.errors == 0 && sb.due_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // overall time limit
  initial begin
    #(RUN_LIMIT);
    $display("FAILURE");
    $finish;
  end

endmodule
